// ===== rtl/dnd_pkg.sv =====
// Package for the DNS name decompressor: shared types, constants and state encodings.
// No dependencies. Used by dnd_name_emitter and dns_name_decompressor_unit.
`default_nettype none

package dnd_pkg;

   // Default sizes of the packet store and of the dotted name buffer.
   localparam int PACKET_BYTES_DEF = 2048;
   localparam int NAME_CHARS_DEF   = 255;

   // Packet positions are carried this wide for every legal store size.
   localparam int POS_W = 15;

   // Field widths of the command and result beats.
   localparam int ADDRESS_W   = 11;
   localparam int PKT_LEN_W   = 12;
   localparam int NAME_LEN_W  = 8;
   localparam int OFFSET_W    = 12;
   localparam int JUMP_W      = 6;
   localparam int CHUNK_CHARS = 8;
   localparam int CHUNK_W     = 64;
   localparam int CHUNK_CNT_W = 4;
   localparam int LANE_W      = 3;

   // Label length byte tags and other protocol constants.
   localparam logic [1:0] TAG_LABEL   = 2'b00;
   localparam logic [1:0] TAG_POINTER = 2'b11;
   localparam logic [7:0] DOT_CHAR    = 8'h2e;
   localparam logic [JUMP_W-1:0] JUMP_LIMIT_RESET = 6'd16;

   // Command codes.
   localparam logic CMD_WRITE  = 1'b0;
   localparam logic CMD_DECODE = 1'b1;

   // Label walker sequencer states.
   typedef enum logic [2:0] {
      W_IDLE,
      W_EVAL_LAB,
      W_EVAL_PTR,
      W_COPY,
      W_FETCH_LAB
   } walk_state_type;

   // Chunk emitter states.
   typedef enum logic [1:0] {
      E_IDLE,
      E_FILL,
      E_SEND
   } emit_state_type;

   // One write into the name buffer.
   typedef struct packed {
      logic                  en;
      logic [NAME_LEN_W-1:0] addr;
      logic [7:0]            data;
   } name_wr_type;

   // Launch of the result sequence once the walk has finished.
   typedef struct packed {
      logic                  go;
      logic                  error;
      logic [NAME_LEN_W-1:0] length;
      logic [OFFSET_W-1:0]   resume;
   } emit_cmd_type;

endpackage

`default_nettype wire

// ===== rtl/dnd_name_emitter.sv =====
// Name buffer and chunk emitter: holds the dotted name and sends it in 8-byte beats.
// Depends on dnd_pkg.
`default_nettype none

module dnd_name_emitter #(
   parameter int NAME_CHARS = dnd_pkg::NAME_CHARS_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  dnd_pkg::name_wr_type                    name_wr,
   input  dnd_pkg::emit_cmd_type                   emit_cmd,
   output logic                                    emit_busy,
   output logic                                    rsp_strobe,
   output logic [dnd_pkg::CHUNK_W-1:0]             rsp_name_chunk,
   output logic [dnd_pkg::CHUNK_CNT_W-1:0]         rsp_chunk_bytes,
   output logic                                    rsp_last,
   output logic                                    rsp_status,
   output logic [dnd_pkg::OFFSET_W-1:0]            rsp_next_offset,
   output logic [dnd_pkg::NAME_LEN_W-1:0]          rsp_name_length
);
   import dnd_pkg::*;

   localparam int NAME_W = $clog2(NAME_CHARS);

   emit_state_type state_ff, state_in;

   logic [7:0]             name_mem [NAME_CHARS];
   logic [7:0]             rdata_ff;
   logic [NAME_LEN_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [NAME_LEN_W-1:0]  len_ff, len_in;
   logic [OFFSET_W-1:0]    resume_ff, resume_in;
   logic                   err_ff, err_in;
   logic [CHUNK_CNT_W-1:0] n_ff, n_in;
   logic [CHUNK_CNT_W-1:0] issued_ff, issued_in;
   logic                   rd_valid_ff, rd_valid_in;
   logic [LANE_W-1:0]      lane_ff, lane_in;
   logic [CHUNK_W-1:0]     chunk_ff, chunk_in;
   logic [NAME_LEN_W-1:0]  left;
   logic                   fill_done;
   logic                   chunk_last;

   // Name buffer: one write port from the walker, one registered read port.
   always_ff @(posedge clock) begin
      if (name_wr.en) begin
         name_mem[name_wr.addr[NAME_W-1:0]] <= name_wr.data;
      end
      rdata_ff <= name_mem[rd_ptr_ff[NAME_W-1:0]];
   end

   // Characters still to send and the end of the current chunk.
   always_comb begin
      left       = len_ff - rd_ptr_ff;
      fill_done  = (issued_ff == n_ff);
      chunk_last = (rd_ptr_ff >= len_ff);
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         E_IDLE: begin
            if (emit_cmd.go) begin
               state_in = emit_cmd.error ? E_SEND : E_FILL;
            end
         end
         E_FILL: begin
            if (fill_done) begin
               state_in = E_SEND;
            end
         end
         E_SEND: begin
            state_in = chunk_last ? E_IDLE : E_FILL;
         end
         default: state_in = E_IDLE;
      endcase
   end

   // Datapath: read issue, lane placement and chunk bookkeeping.
   always_comb begin
      rd_ptr_in   = rd_ptr_ff;
      len_in      = len_ff;
      resume_in   = resume_ff;
      err_in      = err_ff;
      n_in        = n_ff;
      issued_in   = issued_ff;
      lane_in     = issued_ff[LANE_W-1:0];
      rd_valid_in = 1'b0;
      chunk_in    = chunk_ff;
      if (rd_valid_ff) begin
         chunk_in[(CHUNK_CHARS - 1 - int'(lane_ff)) * 8 +: 8] = rdata_ff;
      end
      case (state_ff)
         E_IDLE: begin
            if (emit_cmd.go) begin
               rd_ptr_in = '0;
               issued_in = '0;
               chunk_in  = '0;
               err_in    = emit_cmd.error;
               if (emit_cmd.error) begin
                  len_in    = '0;
                  resume_in = '0;
                  n_in      = '0;
               end else begin
                  len_in    = emit_cmd.length;
                  resume_in = emit_cmd.resume;
                  n_in      = (emit_cmd.length > NAME_LEN_W'(CHUNK_CHARS)) ?
                              CHUNK_CNT_W'(CHUNK_CHARS) : emit_cmd.length[CHUNK_CNT_W-1:0];
               end
            end
         end
         E_FILL: begin
            if (!fill_done) begin
               rd_ptr_in   = rd_ptr_ff + 1'b1;
               issued_in   = issued_ff + 1'b1;
               rd_valid_in = 1'b1;
            end
         end
         E_SEND: begin
            issued_in = '0;
            chunk_in  = '0;
            n_in      = (left > NAME_LEN_W'(CHUNK_CHARS)) ?
                        CHUNK_CNT_W'(CHUNK_CHARS) : left[CHUNK_CNT_W-1:0];
         end
         default: begin
            issued_in = '0;
         end
      endcase
   end

   // Result beat outputs.
   always_comb begin
      emit_busy       = (state_ff != E_IDLE);
      rsp_strobe      = (state_ff == E_SEND);
      rsp_name_chunk  = chunk_ff;
      rsp_chunk_bytes = n_ff;
      rsp_last        = chunk_last;
      rsp_status      = err_ff;
      rsp_next_offset = resume_ff;
      rsp_name_length = len_ff;
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= E_IDLE;
         rd_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         rd_valid_ff <= rd_valid_in;
      end
      rd_ptr_ff <= rd_ptr_in;
      len_ff    <= len_in;
      resume_ff <= resume_in;
      err_ff    <= err_in;
      n_ff      <= n_in;
      issued_ff <= issued_in;
      lane_ff   <= lane_in;
      chunk_ff  <= chunk_in;
   end

endmodule

`default_nettype wire

// ===== rtl/dns_name_decompressor_unit.sv =====
// Top level of the DNS name decompressor: packet store, label walker and configuration.
// Depends on dnd_pkg and dnd_name_emitter.
//
// Usage:
//   A command beat is taken when start is high and busy is low. A write command
//   stores req_data_byte at req_address and gives no result; busy
//   stays low, so writes can stream one per cycle.
//   A decode command walks the name at req_address in the stored packet. The
//   walker reads one packet byte per cycle from the single read port of the
//   packet store: it evaluates each label length byte, copies each label
//   character, reads the second byte of each compression pointer and fetches
//   the next length byte after each label. The name is then sent as result
//   beats of up to 8 characters; the name buffer is read one byte per cycle.
//   A malformed name gives one error beat from the emitter's send state.
//   busy stays high from the cycle after a decode is taken until its last beat
//   has gone. Each result beat is on the rsp_ ports for exactly one cycle,
//   marked by rsp_strobe; the receiver cannot hold it off.
//   jump_limit is written through csr_valid / csr_ready while the block is idle.
//   Synchronous reset returns both sequencers to idle and jump_limit to 16;
//   the packet store and the name buffer are not cleared.
`default_nettype none

module dns_name_decompressor_unit #(
   parameter int PACKET_BYTES = dnd_pkg::PACKET_BYTES_DEF,
   parameter int NAME_CHARS   = dnd_pkg::NAME_CHARS_DEF
) (
   input  wire                                     clock,
   input  wire                                     reset,
   input  wire                                     start,
   output logic                                    busy,
   input  wire                                     req_command,
   input  wire  [dnd_pkg::ADDRESS_W-1:0]           req_address,
   input  wire  [7:0]                              req_data_byte,
   input  wire  [dnd_pkg::PKT_LEN_W-1:0]           req_packet_length,
   input  wire                                     csr_valid,
   output logic                                    csr_ready,
   input  wire  [dnd_pkg::JUMP_W-1:0]              csr_data,
   output logic                                    rsp_strobe,
   output logic [dnd_pkg::CHUNK_W-1:0]             rsp_name_chunk,
   output logic [dnd_pkg::CHUNK_CNT_W-1:0]         rsp_chunk_bytes,
   output logic                                    rsp_last,
   output logic                                    rsp_status,
   output logic [dnd_pkg::OFFSET_W-1:0]            rsp_next_offset,
   output logic [dnd_pkg::NAME_LEN_W-1:0]          rsp_name_length
);
   import dnd_pkg::*;

   localparam int ADDR_W = $clog2(PACKET_BYTES);
   localparam logic [POS_W-1:0] STORE_END = POS_W'(PACKET_BYTES);
   localparam logic [NAME_LEN_W:0] NAME_MAX = (NAME_LEN_W + 1)'(NAME_CHARS);

   walk_state_type state_ff, state_in;

   logic [7:0]            pkt_mem [PACKET_BYTES];
   logic [7:0]            rd_data_ff;
   logic [POS_W-1:0]      rd_addr;

   logic [POS_W-1:0]      len_ff, len_in;
   logic [POS_W-1:0]      cursor_ff, cursor_in;
   logic [POS_W-1:0]      next_ff, next_in;
   logic [JUMP_W-1:0]     jumps_ff, jumps_in;
   logic                  jumped_ff, jumped_in;
   logic [NAME_LEN_W-1:0] size_ff, size_in;
   logic [5:0]            remain_ff, remain_in;
   logic [5:0]            ptr_hi_ff, ptr_hi_in;
   logic                  copy_wr_ff;
   logic                  copy_wr_in;
   logic [JUMP_W-1:0]     limit_ff;

   logic                  take;
   logic                  take_decode;
   logic [POS_W-1:0]      addr_ext;
   logic [POS_W-1:0]      len_sat;
   logic                  start_bad;
   logic [POS_W-1:0]      cur1;
   logic [POS_W-1:0]      lab_len;
   logic                  is_ptr;
   logic                  ptr_bad;
   logic                  lab_bad;
   logic                  is_term;
   logic [NAME_LEN_W:0]   s1;
   logic                  name_bad;
   logic [POS_W-1:0]      target;
   logic                  tgt_bad;
   logic                  end_bad;
   logic                  emit_busy;
   name_wr_type           name_wr;
   emit_cmd_type          emit_cmd;

   // Command acceptance and the saturated packet length.
   always_comb begin
      take        = start && !busy;
      take_decode = take && (req_command == CMD_DECODE);
      addr_ext    = POS_W'(req_address);
      len_sat     = (POS_W'(req_packet_length) > STORE_END) ?
                    STORE_END : POS_W'(req_packet_length);
      start_bad   = (addr_ext >= len_sat);
   end

   // Checks on the byte just read from the packet store.
   always_comb begin
      cur1     = cursor_ff + 1'b1;
      lab_len  = POS_W'(rd_data_ff[5:0]);
      is_ptr   = (rd_data_ff[7:6] == TAG_POINTER);
      ptr_bad  = (cur1 >= len_ff) || (jumps_ff >= limit_ff);
      lab_bad  = (rd_data_ff[7:6] != TAG_LABEL) || ((cur1 + lab_len) > len_ff);
      is_term  = (rd_data_ff[5:0] == 6'd0);
      s1       = (NAME_LEN_W + 1)'(size_ff) + ((size_ff != '0) ? 1'b1 : 1'b0);
      name_bad = ((size_ff != '0) && ((NAME_LEN_W + 1)'(size_ff) >= NAME_MAX)) ||
                 ((NAME_LEN_W + 1)'(rd_data_ff[5:0]) > (NAME_MAX - s1));
      target   = POS_W'({ptr_hi_ff, rd_data_ff});
      tgt_bad  = (target >= len_ff) || (target >= cursor_ff);
      end_bad  = (cursor_ff >= len_ff);
   end

   // Packet store read address: the byte the next state will look at.
   always_comb begin
      case (state_ff)
         W_IDLE:     rd_addr = addr_ext;
         W_EVAL_LAB: rd_addr = cur1;
         W_EVAL_PTR: rd_addr = target;
         default:    rd_addr = cursor_ff;
      endcase
   end

   // Packet store: write port for write commands, one registered read port.
   always_ff @(posedge clock) begin
      if (take && (req_command == CMD_WRITE) && (addr_ext < STORE_END)) begin
         pkt_mem[addr_ext[ADDR_W-1:0]] <= req_data_byte;
      end
      rd_data_ff <= pkt_mem[rd_addr[ADDR_W-1:0]];
   end

   // Walker next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         W_IDLE: begin
            if (take_decode && !start_bad) begin
               state_in = W_EVAL_LAB;
            end
         end
         W_EVAL_LAB: begin
            if (is_ptr) begin
               state_in = ptr_bad ? W_IDLE : W_EVAL_PTR;
            end else if (lab_bad || is_term || name_bad) begin
               state_in = W_IDLE;
            end else begin
               state_in = W_COPY;
            end
         end
         W_EVAL_PTR: begin
            state_in = tgt_bad ? W_IDLE : W_EVAL_LAB;
         end
         W_COPY: begin
            if (remain_ff == 6'd1) begin
               state_in = W_FETCH_LAB;
            end
         end
         W_FETCH_LAB: begin
            state_in = end_bad ? W_IDLE : W_EVAL_LAB;
         end
         default: state_in = W_IDLE;
      endcase
   end

   // Walker outputs: launch of the result sequence.
   always_comb begin
      emit_cmd        = '0;
      emit_cmd.length = size_ff;
      emit_cmd.resume = jumped_ff ? next_ff[OFFSET_W-1:0] : cur1[OFFSET_W-1:0];
      case (state_ff)
         W_IDLE: begin
            if (take_decode && start_bad) begin
               emit_cmd.go    = 1'b1;
               emit_cmd.error = 1'b1;
            end
         end
         W_EVAL_LAB: begin
            if (is_ptr) begin
               emit_cmd.go    = ptr_bad;
               emit_cmd.error = 1'b1;
            end else if (lab_bad) begin
               emit_cmd.go    = 1'b1;
               emit_cmd.error = 1'b1;
            end else if (is_term) begin
               emit_cmd.go    = 1'b1;
            end else if (name_bad) begin
               emit_cmd.go    = 1'b1;
               emit_cmd.error = 1'b1;
            end
         end
         W_EVAL_PTR: begin
            emit_cmd.go    = tgt_bad;
            emit_cmd.error = 1'b1;
         end
         W_FETCH_LAB: begin
            emit_cmd.go    = end_bad;
            emit_cmd.error = 1'b1;
         end
         default: emit_cmd.go = 1'b0;
      endcase
   end

   // Walker datapath: cursor, pointer bookkeeping and name buffer writes.
   always_comb begin
      len_in     = len_ff;
      cursor_in  = cursor_ff;
      next_in    = next_ff;
      jumps_in   = jumps_ff;
      jumped_in  = jumped_ff;
      size_in    = size_ff;
      remain_in  = remain_ff;
      ptr_hi_in  = ptr_hi_ff;
      copy_wr_in = (state_ff == W_COPY);
      name_wr    = '0;

      // A label character read in the previous cycle lands in the buffer.
      if (copy_wr_ff) begin
         name_wr.en   = 1'b1;
         name_wr.addr = size_ff;
         name_wr.data = rd_data_ff;
         size_in      = size_ff + 1'b1;
      end

      case (state_ff)
         W_IDLE: begin
            if (take_decode) begin
               len_in    = len_sat;
               cursor_in = addr_ext;
               jumps_in  = '0;
               jumped_in = 1'b0;
               size_in   = '0;
            end
         end
         W_EVAL_LAB: begin
            if (is_ptr) begin
               ptr_hi_in = rd_data_ff[5:0];
            end else if (!lab_bad && !is_term && !name_bad) begin
               // Separator before every label but the first.
               if (size_ff != '0) begin
                  name_wr.en   = 1'b1;
                  name_wr.addr = size_ff;
                  name_wr.data = DOT_CHAR;
               end
               size_in   = s1[NAME_LEN_W-1:0];
               remain_in = rd_data_ff[5:0];
               cursor_in = cur1;
            end
         end
         W_EVAL_PTR: begin
            if (!tgt_bad) begin
               cursor_in = target;
               jumps_in  = jumps_ff + 1'b1;
               if (!jumped_ff) begin
                  next_in   = cursor_ff + POS_W'(2);
                  jumped_in = 1'b1;
               end
            end
         end
         W_COPY: begin
            cursor_in = cur1;
            remain_in = remain_ff - 1'b1;
         end
         default: begin
            remain_in = remain_ff;
         end
      endcase
   end

   // Block busy while walking or sending; configuration taken while idle.
   always_comb begin
      busy      = (state_ff != W_IDLE) || emit_busy;
      csr_ready = !busy;
   end

   // Registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= W_IDLE;
         copy_wr_ff <= 1'b0;
         limit_ff   <= JUMP_LIMIT_RESET;
      end else begin
         state_ff   <= state_in;
         copy_wr_ff <= copy_wr_in;
         if (csr_valid && csr_ready) begin
            limit_ff <= csr_data;
         end
      end
      len_ff    <= len_in;
      cursor_ff <= cursor_in;
      next_ff   <= next_in;
      jumps_ff  <= jumps_in;
      jumped_ff <= jumped_in;
      size_ff   <= size_in;
      remain_ff <= remain_in;
      ptr_hi_ff <= ptr_hi_in;
   end

   // Name buffer and result beats.
   dnd_name_emitter #(
      .NAME_CHARS(NAME_CHARS)
   ) u_emitter (
      .clock          (clock),
      .reset          (reset),
      .name_wr        (name_wr),
      .emit_cmd       (emit_cmd),
      .emit_busy      (emit_busy),
      .rsp_strobe     (rsp_strobe),
      .rsp_name_chunk (rsp_name_chunk),
      .rsp_chunk_bytes(rsp_chunk_bytes),
      .rsp_last       (rsp_last),
      .rsp_status     (rsp_status),
      .rsp_next_offset(rsp_next_offset),
      .rsp_name_length(rsp_name_length)
   );

endmodule

`default_nettype wire
